@@ rtl/fifo_ready_queue_scheduler_macros.svh @@
// assertion macros for the ready queue checker
`ifndef FIFO_READY_QUEUE_SCHEDULER_MACROS_SVH
`define FIFO_READY_QUEUE_SCHEDULER_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define FRQS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ready queue check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define FRQS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ready queue check failed");

`endif

@@ rtl/frqs_pkg.sv @@
// shared types and codes for the ready queue scheduler
package frqs_pkg;

  // operation codes carried on in_tuser
  localparam logic [1:0] KIND_ADD   = 2'd0;
  localparam logic [1:0] KIND_YIELD = 2'd1;
  localparam logic [1:0] KIND_TERM  = 2'd2;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 24;

  // per-cycle command broadcast to every queue cell
  typedef struct packed {
    logic shift;  // take the right neighbor's entry
    logic load;   // the cell at load_pos takes load_data (wins over shift)
  } cell_ctrl_t;

endpackage

@@ rtl/frqs_cell.sv @@
// one queue slot: holds an entry, loads or shifts it toward the head
module frqs_cell
  import frqs_pkg::*;
#(
  parameter int ID_BITS = 8,
  parameter int POS_W   = 4,
  parameter int IDX     = 0
) (
  input  logic               clk,
  input  cell_ctrl_t         ctrl,
  input  logic [POS_W-1:0]   load_pos,
  input  logic [ID_BITS-1:0] load_data,
  input  logic [ID_BITS-1:0] right_in,
  output logic [ID_BITS-1:0] entry_q
);

  logic [ID_BITS-1:0] entry_r;
  logic [ID_BITS-1:0] entry_nxt;
  logic               hit;

  assign hit = ctrl.load && (load_pos == POS_W'(IDX));

  always_comb begin
    priority if (hit) begin
      entry_nxt = load_data;
    end else if (ctrl.shift) begin
      entry_nxt = right_in;
    end else begin
      entry_nxt = entry_r;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_q = entry_r;

endmodule

@@ rtl/fifo_ready_queue_scheduler.sv @@
// ready queue scheduler top level: fifo of thread ids with removal by value
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------------------
//  in_     | input     | in_tvalid / in_tready | tuser: kind, tdata: thread_id
//  out_    | output    | out_tvalid/out_tready | tdata: dispatched .. occupancy
//
// for add, yield and the undefined kind the result word is
// registered and shows on out_ the cycle after the input word is taken.
// terminate walks the cell row once per stored entry in the single
// head-to-tail rotation pass, then registers its result word.
// one word is in flight at a time; a stalled result word holds in_tready low.
// rst_n is synchronous and active low; it empties the queue, entries stay
// undefined until written.
module fifo_ready_queue_scheduler
  import frqs_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input words
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] thread_id
  input  logic [1:0]             in_tuser,   // [1:0] kind
  // result words
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // [0] dispatched, [8:1] dispatched_id,
                                             // [13:9] removed_count, [14] dropped,
                                             // [19:15] occupancy, [23:20] zero
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int POS_W = $clog2(QUEUE_DEPTH);

  // controller states
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  // cell row
  logic [ID_BITS-1:0] cell_q [QUEUE_DEPTH];
  cell_ctrl_t         ctrl;
  logic [POS_W-1:0]   load_pos;
  logic [ID_BITS-1:0] load_data;

  for (genvar gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
    logic [ID_BITS-1:0] right_in;
    if (gi == QUEUE_DEPTH - 1) begin : g_tail
      // tail cell keeps its own value on a shift, it is past the count anyway
      assign right_in = cell_q[gi];
    end else begin : g_mid
      assign right_in = cell_q[gi+1];
    end
    frqs_cell #(
      .ID_BITS (ID_BITS),
      .POS_W   (POS_W),
      .IDX     (gi)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .load_pos  (load_pos),
      .load_data (load_data),
      .right_in  (right_in),
      .entry_q   (cell_q[gi])
    );
  end

  // control state
  logic               state_r,  state_nxt;
  logic [CNT_W-1:0]   cnt_r,    cnt_nxt;   // valid entries, head at cell 0
  logic [CNT_W-1:0]   rem_r,    rem_nxt;   // entries left to visit in a scan
  logic [CNT_W-1:0]   rmv_r,    rmv_nxt;   // entries dropped so far in a scan
  logic [ID_BITS-1:0] tid_r,    tid_nxt;   // id being terminated
  logic               out_valid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  // id sizing between the 8-bit field and the stored width
  logic [ID_BITS+7:0] id_wide;
  logic [ID_BITS-1:0] id_in;
  logic [ID_BITS+7:0] head_wide;
  logic [7:0]         head_byte;

  assign id_wide   = {{ID_BITS{1'b0}}, in_tdata};
  assign id_in     = id_wide[ID_BITS-1:0];
  assign head_wide = {8'h00, cell_q[0]};
  assign head_byte = head_wide[7:0];

  logic             in_acc;
  logic             keep;
  logic [CNT_W-1:0] cnt_m1;
  logic [CNT_W-1:0] rmv_inc;

  // result fields of the word being finished
  logic             res_load;
  logic             r_disp;
  logic [7:0]       r_did;
  logic [CNT_W-1:0] r_rmv;
  logic             r_drop;
  logic [CNT_W+4:0] occ_w;
  logic [CNT_W+4:0] rmv_w;

  assign in_tready = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;
  assign keep      = (cell_q[0] != tid_r);
  assign cnt_m1    = cnt_r - 1'b1;
  assign rmv_inc   = keep ? rmv_r : rmv_r + 1'b1;

  always_comb begin
    ctrl      = '0;
    load_pos  = cnt_r[POS_W-1:0];
    load_data = id_in;
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    rmv_nxt   = rmv_r;
    tid_nxt   = tid_r;
    res_load  = 1'b0;
    r_disp    = 1'b0;
    r_did     = 8'h00;
    r_rmv     = '0;
    r_drop    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_tuser)
            KIND_ADD: begin
              res_load = 1'b1;
              if (cnt_r < CNT_W'(QUEUE_DEPTH)) begin
                ctrl.load = 1'b1;
                cnt_nxt   = cnt_r + 1'b1;
              end else begin
                r_drop = 1'b1;
              end
            end
            KIND_YIELD: begin
              res_load = 1'b1;
              if (cnt_r != '0) begin
                ctrl.shift = 1'b1;
                r_disp     = 1'b1;
                r_did      = head_byte;
                cnt_nxt    = cnt_m1;
              end
            end
            KIND_TERM: begin
              tid_nxt = id_in;
              rmv_nxt = '0;
              if (cnt_r == '0) begin
                res_load = 1'b1;
              end else begin
                rem_nxt   = cnt_r;
                state_nxt = ST_SCAN;
              end
            end
            default: begin
              // undefined kind: no change, occupancy only
              res_load = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        // pop the head; a survivor goes back in at the tail of what is left
        ctrl.shift = 1'b1;
        ctrl.load  = keep;
        load_pos   = cnt_m1[POS_W-1:0];
        load_data  = cell_q[0];
        cnt_nxt    = keep ? cnt_r : cnt_m1;
        rmv_nxt    = rmv_inc;
        rem_nxt    = rem_r - 1'b1;
        if (rem_r == CNT_W'(1)) begin
          res_load  = 1'b1;
          r_rmv     = rmv_inc;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign occ_w = {5'b00000, cnt_nxt};
  assign rmv_w = {5'b00000, r_rmv};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      rem_r       <= '0;
      rmv_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      rem_r   <= rem_nxt;
      rmv_r   <= rmv_nxt;
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    tid_r <= tid_nxt;
    if (res_load) begin
      out_tdata_r <= {4'b0000, occ_w[4:0], r_drop, rmv_w[4:0], r_did, r_disp};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

endmodule

@@ rtl/frqs_checker.sv @@
// port-level checks for the ready queue scheduler, bound to the top level
`include "fifo_ready_queue_scheduler_macros.svh"

module frqs_checker #(
  parameter int QUEUE_DEPTH = 16
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // result word fields
  logic       disp_bit;
  logic [7:0] disp_id;
  logic       drop_bit;
  logic [4:0] occ;

  assign disp_bit = out_tdata[0];
  assign disp_id  = out_tdata[8:1];
  assign drop_bit = out_tdata[14];
  assign occ      = out_tdata[19:15];

  // a held result word keeps its value
  `FRQS_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // no new word is taken while a result word waits
  `FRQS_ASSERT_IMP(a_no_take_on_stall, out_tvalid && !out_tready, !in_tready)

  // no dispatch means a zero id
  `FRQS_ASSERT_IMP(a_idle_id_zero, out_tvalid && !disp_bit, disp_id == 8'h00)

  // a word never both dispatches and drops
  `FRQS_ASSERT_IMP(a_disp_no_drop, out_tvalid && disp_bit, !drop_bit)

  // occupancy stays within the queue depth
  `FRQS_ASSERT_IMP(a_occ_bound, out_tvalid, {27'd0, occ} <= 32'(QUEUE_DEPTH))

endmodule

bind fifo_ready_queue_scheduler frqs_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_frqs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ dv/fifo_ready_queue_scheduler_tb.sv @@
`timescale 1ns / 1ps
// self-checking stream testbench for the fifo ready queue scheduler
module fifo_ready_queue_scheduler_tb;
  import frqs_pkg::*;

  localparam int QUEUE_DEPTH    = 16;
  localparam int ID_BITS        = 8;
  localparam int RANDOM_ITEMS   = 1225;
  localparam int CALM_TAIL      = 150;   // last random words go with no idling
  localparam int LONG_STALL     = 300;   // receiver hold-off that backs up the input
  localparam int SETTLE_CYCLES  = 40;    // longer than a full terminate walk
  localparam int WATCHDOG_LIMIT = 2000;  // quiet cycles before the run is given up

  // kind 3 carries no operation; the block just reports occupancy
  localparam logic [1:0] KIND_NONE = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] tid;
  } sched_req_t;

  typedef struct packed {
    logic       dispatched;
    logic [7:0] disp_id;
    logic [4:0] removed;
    logic       dropped;
    logic [4:0] occupancy;
  } sched_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;    // [7:0] thread_id
  logic [1:0]             in_tuser = '0;    // [1:0] kind
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;        // [0] dispatched, [8:1] dispatched_id,
                                            // [13:9] removed_count, [14] dropped,
                                            // [19:15] occupancy, [23:20] zero

  // shadow of the ready queue, head at index 0
  logic [7:0]    ready_ids[$];
  sched_req_t    pending_reqs[$];
  sched_result_t expected_results[$];

  logic in_taken = 1'b0;     // a word went in at the last rising edge
  logic idle_on = 1'b1;      // random bursts of idling on both sides
  logic rx_long_req = 1'b0;  // ask the receiver for one long hold-off
  int   tx_idle_left = 0;
  int   rx_stall_left = 0;
  int   fail_count = 0;
  int   quiet_cycles = 0;

  fifo_ready_queue_scheduler #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .ID_BITS    (ID_BITS)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // advance the shadow queue by one operation and return the word it should produce
  function automatic sched_result_t apply_sched_op(input logic [1:0] kind,
                                                   input logic [7:0] tid);
    sched_result_t res;
    logic [7:0]    kept[$];
    res = '0;
    case (kind)
      KIND_ADD: begin
        if (ready_ids.size() < QUEUE_DEPTH) ready_ids.push_back(tid);
        else res.dropped = 1'b1;
      end
      KIND_YIELD: begin
        if (ready_ids.size() > 0) begin
          res.dispatched = 1'b1;
          res.disp_id    = ready_ids.pop_front();
        end
      end
      KIND_TERM: begin
        // drop every match, survivors keep their order
        foreach (ready_ids[i]) begin
          if (ready_ids[i] == tid) res.removed = res.removed + 5'd1;
          else kept.push_back(ready_ids[i]);
        end
        ready_ids = kept;
      end
      default: ;
    endcase
    res.occupancy = 5'(ready_ids.size());
    return res;
  endfunction

  task automatic check_field(input string name, input int exp_val, input int got_val);
    if (exp_val != got_val) begin
      $error("%s: expected %0d, actual %0d", name, exp_val, got_val);
      fail_count++;
    end
  endtask

  task automatic check_result(input sched_result_t exp_res, input logic [23:0] word);
    check_field("dispatched", exp_res.dispatched, word[0]);
    check_field("dispatched_id", exp_res.disp_id, word[8:1]);
    check_field("removed_count", exp_res.removed, word[13:9]);
    check_field("dropped", exp_res.dropped, word[14]);
    check_field("occupancy", exp_res.occupancy, word[19:15]);
    check_field("pad", 0, word[23:20]);
  endtask

  task automatic push_req(input logic [1:0] kind, input logic [7:0] tid);
    sched_req_t req;
    req.kind = kind;
    req.tid  = tid;
    pending_reqs.push_back(req);
  endtask

  // hold the sender until every result word has come back
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  // sender: new word or idle only once the current word is gone
  always @(negedge clk) begin
    logic       drive_valid;
    sched_req_t req;
    drive_valid = in_tvalid;
    if (!rst_n) begin
      drive_valid = 1'b0;
    end else if (!in_tvalid || in_taken) begin
      drive_valid = 1'b0;
      if (tx_idle_left > 0) begin
        tx_idle_left--;
      end else if (pending_reqs.size() > 0) begin
        if (idle_on && $urandom_range(0, 7) == 0) begin
          tx_idle_left = $urandom_range(1, 17) - 1;
        end else begin
          req = pending_reqs.pop_front();
          in_tuser    <= req.kind;
          in_tdata    <= req.tid;
          drive_valid = 1'b1;
        end
      end
    end
    in_tvalid <= drive_valid;
  end

  // receiver: random stall bursts plus the one long hold-off on request
  always @(negedge clk) begin
    logic ready_next;
    ready_next = 1'b1;
    if (rx_stall_left > 0) begin
      rx_stall_left--;
      ready_next = 1'b0;
    end else if (rx_long_req) begin
      rx_long_req   = 1'b0;
      rx_stall_left = LONG_STALL - 1;
      ready_next    = 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      rx_stall_left = $urandom_range(1, 17) - 1;
      ready_next    = 1'b0;
    end
    out_tready <= ready_next;
  end

  // monitor: check the result word first, then queue the prediction for a new input
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_tvalid && in_tready;
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $error("result word %h with no operation outstanding", out_tdata);
          fail_count++;
        end else begin
          check_result(expected_results.pop_front(), out_tdata);
        end
      end
      if (in_tvalid && in_tready)
        expected_results.push_back(apply_sched_op(in_tuser, in_tdata));
    end
  end

  // watchdog on cycles where no word moves on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int         random_sent;
    int         seq_idx;
    int         seq_len;
    int         pick;
    logic [7:0] id_pool[3];
    logic [7:0] flood_id;
    logic [1:0] kind;

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty queue corners, id extremes, removal at head, middle and tail
    push_req(KIND_YIELD, 8'h00);   // yield on an empty queue
    push_req(KIND_TERM, 8'h00);    // terminate on an empty queue
    push_req(KIND_NONE, 8'hff);    // undefined kind does nothing
    push_req(KIND_ADD, 8'hff);
    push_req(KIND_ADD, 8'h00);
    push_req(KIND_ADD, 8'hff);
    push_req(KIND_ADD, 8'h5a);
    push_req(KIND_ADD, 8'ha5);
    push_req(KIND_NONE, 8'h00);
    push_req(KIND_TERM, 8'hff);    // takes the head and a middle entry
    push_req(KIND_TERM, 8'ha5);    // takes the tail
    push_req(KIND_TERM, 8'h33);    // absent id, queue unchanged
    push_req(KIND_ADD, 8'h80);
    push_req(KIND_ADD, 8'h01);
    push_req(KIND_YIELD, 8'hff);   // id is ignored on yield
    push_req(KIND_YIELD, 8'h00);
    push_req(KIND_YIELD, 8'h00);
    push_req(KIND_YIELD, 8'h00);
    push_req(KIND_YIELD, 8'h00);   // empty again
    wait_drained();

    // random sequences: fill, drain, flood-and-kill and mixed traffic over a small id pool
    random_sent = 0;
    seq_idx     = 0;
    while (random_sent < RANDOM_ITEMS) begin
      foreach (id_pool[i]) id_pool[i] = 8'($urandom_range(0, 255));
      idle_on = (random_sent < RANDOM_ITEMS - CALM_TAIL) && ($urandom_range(0, 3) != 0);
      pick    = $urandom_range(0, 9);
      if (pick <= 2) begin
        // fill, often far enough to overflow and drop
        seq_len = $urandom_range(8, 20);
        repeat (seq_len) push_req(KIND_ADD,
          ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                      : id_pool[$urandom_range(0, 2)]);
      end else if (pick <= 4) begin
        // drain, often past empty
        seq_len = $urandom_range(4, 18);
        repeat (seq_len) push_req(KIND_YIELD, 8'($urandom_range(0, 255)));
      end else if (pick == 5) begin
        // one id into every free slot and past full, then terminate it
        flood_id = 8'($urandom_range(0, 255));
        seq_len  = $urandom_range(QUEUE_DEPTH, QUEUE_DEPTH + 2) + 1;
        repeat (seq_len - 1) push_req(KIND_ADD, flood_id);
        push_req(KIND_TERM, flood_id);
      end else begin
        seq_len = $urandom_range(10, 30);
        repeat (seq_len) begin
          pick = $urandom_range(0, 99);
          if (pick < 40) kind = KIND_ADD;
          else if (pick < 70) kind = KIND_YIELD;
          else if (pick < 95) kind = KIND_TERM;
          else kind = KIND_NONE;
          push_req(kind, ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                                     : id_pool[$urandom_range(0, 2)]);
        end
      end
      random_sent += seq_len;
      seq_idx++;

      // one long receiver hold-off while the sender keeps offering words
      if (seq_idx == 6) rx_long_req = 1'b1;

      if (seq_idx % 9 == 0) wait_drained();
      else while (pending_reqs.size() != 0) @(posedge clk);
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
